### hw/rtl/ffha_pkg.sv
`default_nettype none

package ffha_pkg;

  // Tag words are 16 bits; bit 0 marks the block as allocated.
  localparam int unsigned TagW = 16;
  // Byte positions reach the heap span itself, up to 65536.
  localparam int unsigned PosW = 17;
  // Position plus a full block size.
  localparam int unsigned SumW = 18;

  localparam logic [1:0] STATUS_GRANT   = 2'd0;
  localparam logic [1:0] STATUS_TOO_BIG = 2'd1;
  localparam logic [1:0] STATUS_NO_FIT  = 2'd2;

  typedef enum logic [2:0] {
    ST_INIT_HDR,
    ST_INIT_FTR,
    ST_IDLE,
    ST_WALK,
    ST_WR_FOOT,
    ST_WR_RHDR,
    ST_WR_RFOOT,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

### hw/rtl/ffha_ram.sv
`default_nettype none

module ffha_ram #(
  parameter int unsigned Depth = 2048,
  parameter int unsigned AddrW = 11
) (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic [AddrW-1:0]           waddr_i,
  input  wire logic [ffha_pkg::TagW-1:0]  wdata_i,
  input  wire logic [AddrW-1:0]           raddr_i,
  output logic      [ffha_pkg::TagW-1:0]  rdata_o
);
  import ffha_pkg::*;

  logic [TagW-1:0] mem_q [Depth];
  logic [TagW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hw/rtl/ffha_ctrl.sv
`default_nettype none

module ffha_ctrl #(
  parameter int unsigned HeapBytes = 4096,
  parameter int unsigned AddrW     = 11
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [15:0]                request_size_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic      [1:0]                 status_o,
  output logic      [15:0]                payload_address_o,
  output logic                            mem_we_o,
  output logic      [AddrW-1:0]           mem_waddr_o,
  output logic      [ffha_pkg::TagW-1:0]  mem_wdata_o,
  output logic      [AddrW-1:0]           mem_raddr_o,
  input  wire logic [ffha_pkg::TagW-1:0]  mem_rdata_i
);
  import ffha_pkg::*;

  localparam int unsigned WordCount = HeapBytes / 2;
  localparam int unsigned HeapSpan  = WordCount * 2;
  localparam logic [TagW-1:0]  InitTag  = TagW'(HeapSpan - 4);
  localparam logic [PosW-1:0]  ReqLimit = PosW'(HeapSpan - 4);
  localparam logic [SumW-1:0]  SpanEnd  = SumW'(HeapSpan);
  localparam logic [AddrW-1:0] LastWord = AddrW'(WordCount - 1);

  state_e state_q, state_d;

  logic [PosW-1:0] pos_q, pos_d;
  logic [TagW-1:0] rounded_q, rounded_d;
  logic [TagW-1:0] payload_q, payload_d;
  logic            split_q, split_d;
  logic [1:0]      res_status_q, res_status_d;
  logic [15:0]     res_addr_q, res_addr_d;
  logic            out_valid_q, out_valid_d;
  logic [1:0]      out_status_q, out_status_d;
  logic [15:0]     out_addr_q, out_addr_d;

  logic [TagW-1:0] tag_payload;
  logic            tag_free;
  logic [SumW-1:0] block_end;
  logic            past_end;
  logic            next_stop;
  logic            fits;
  logic            split_now;
  logic [TagW-1:0] rest;
  logic [SumW-1:0] wsum;
  logic            out_load;

  always_comb begin
    tag_payload = {mem_rdata_i[TagW-1:1], 1'b0};
    tag_free    = ~mem_rdata_i[0];
    block_end   = SumW'(pos_q) + SumW'(tag_payload) + SumW'(4);
    past_end    = block_end > SpanEnd;
    next_stop   = (block_end + SumW'(4)) > SpanEnd;
    fits        = tag_free && (tag_payload >= rounded_q);
    split_now   = SumW'(tag_payload) > (SumW'(rounded_q) + SumW'(4));
    rest        = payload_q - rounded_q - TagW'(4);
  end

  assign out_load = !out_valid_q || out_ready_i;

  always_comb begin
    state_d      = state_q;
    pos_d        = pos_q;
    rounded_d    = rounded_q;
    payload_d    = payload_q;
    split_d      = split_q;
    res_status_d = res_status_q;
    res_addr_d   = res_addr_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_addr_d   = out_addr_q;
    in_ready_o   = 1'b0;
    mem_we_o     = 1'b0;
    wsum         = SumW'(pos_q);
    mem_waddr_o  = wsum[AddrW:1];
    mem_wdata_o  = '0;
    mem_raddr_o  = pos_q[AddrW:1];

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_INIT_HDR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = '0;
        mem_wdata_o = InitTag;
        state_d     = ST_INIT_FTR;
      end
      ST_INIT_FTR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = LastWord;
        mem_wdata_o = InitTag;
        state_d     = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          rounded_d = TagW'(request_size_i + {15'd0, request_size_i[0]});
          if (PosW'(request_size_i) >= ReqLimit) begin
            res_status_d = STATUS_TOO_BIG;
            res_addr_d   = '0;
            state_d      = ST_DONE;
          end else begin
            pos_d       = '0;
            mem_raddr_o = '0;
            state_d     = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        // Header of the block at pos_q is on the read port.
        if (past_end) begin
          res_status_d = STATUS_NO_FIT;
          res_addr_d   = '0;
          state_d      = ST_DONE;
        end else if (fits) begin
          payload_d    = tag_payload;
          split_d      = split_now;
          mem_we_o     = 1'b1;
          mem_wdata_o  = split_now ? (rounded_q | TagW'(1)) : (tag_payload | TagW'(1));
          res_status_d = STATUS_GRANT;
          res_addr_d   = 16'(pos_q + PosW'(2));
          state_d      = ST_WR_FOOT;
        end else if (next_stop) begin
          res_status_d = STATUS_NO_FIT;
          res_addr_d   = '0;
          state_d      = ST_DONE;
        end else begin
          // Advance to the next header and fetch it.
          pos_d       = PosW'(block_end);
          mem_raddr_o = block_end[AddrW:1];
        end
      end
      ST_WR_FOOT: begin
        mem_we_o    = 1'b1;
        wsum        = SumW'(pos_q) + SumW'(split_q ? rounded_q : payload_q) + SumW'(2);
        mem_waddr_o = wsum[AddrW:1];
        mem_wdata_o = (split_q ? rounded_q : payload_q) | TagW'(1);
        state_d     = split_q ? ST_WR_RHDR : ST_DONE;
      end
      ST_WR_RHDR: begin
        mem_we_o    = 1'b1;
        wsum        = SumW'(pos_q) + SumW'(rounded_q) + SumW'(4);
        mem_waddr_o = wsum[AddrW:1];
        mem_wdata_o = rest;
        state_d     = ST_WR_RFOOT;
      end
      ST_WR_RFOOT: begin
        mem_we_o    = 1'b1;
        wsum        = SumW'(pos_q) + SumW'(payload_q) + SumW'(2);
        mem_waddr_o = wsum[AddrW:1];
        mem_wdata_o = rest;
        state_d     = ST_DONE;
      end
      ST_DONE: begin
        // Hold the result until the output register is free.
        if (out_load) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_addr_d   = res_addr_q;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT_HDR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q        <= pos_d;
    rounded_q    <= rounded_d;
    payload_q    <= payload_d;
    split_q      <= split_d;
    res_status_q <= res_status_d;
    res_addr_q   <= res_addr_d;
    out_status_q <= out_status_d;
    out_addr_q   <= out_addr_d;
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign payload_address_o = out_addr_q;

endmodule

`default_nettype wire

### hw/rtl/first_fit_heap_allocator.sv
// First-fit heap allocator over a boundary-tagged heap of 16-bit tag words.
// Request channel: in_valid_i / in_ready_o carry request_size_i (bytes).
// Result channel: out_valid_o / out_ready_i carry status_o (0 granted,
// 1 too large, 2 no fitting block) and payload_address_o (0 when refused).
// Each request gives exactly one result, in request order.
// The tag memory has one read port with a registered read, and
// the walk reads one block header per cycle. After acceptance a request
// walks its headers; a no-fit refusal then goes to the result, a
// whole-block grant first makes two tag writes and a split grant four;
// an oversized request skips the walk.
// in_ready_o is high again in the cycle where out_valid_o rises.
// One request is processed at a time; in_ready_o is high only when idle.
// The output register holds the result while the receiver stalls, and the
// next request is accepted and walked meanwhile; it waits at its end until
// the output register is free.
// After reset the block writes the end tags of the single free block that
// spans the heap, in ST_INIT_HDR and ST_INIT_FTR, with in_ready_o low.
`default_nettype none

module first_fit_heap_allocator #(
  parameter int unsigned HEAP_BYTES = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [15:0] request_size_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [1:0]  status_o,
  output logic      [15:0] payload_address_o
);
  import ffha_pkg::*;

  localparam int unsigned WordCount = HEAP_BYTES / 2;
  localparam int unsigned AddrW     = $clog2(WordCount);

  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [TagW-1:0]  mem_wdata;
  logic [AddrW-1:0] mem_raddr;
  logic [TagW-1:0]  mem_rdata;

  ffha_ctrl #(
    .HeapBytes (HEAP_BYTES),
    .AddrW     (AddrW)
  ) u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .request_size_i    (request_size_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .payload_address_o (payload_address_o),
    .mem_we_o          (mem_we),
    .mem_waddr_o       (mem_waddr),
    .mem_wdata_o       (mem_wdata),
    .mem_raddr_o       (mem_raddr),
    .mem_rdata_i       (mem_rdata)
  );

  ffha_ram #(
    .Depth (WordCount),
    .AddrW (AddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

`default_nettype wire

### dv/first_fit_heap_allocator_tb.sv
`timescale 1ns / 100ps

module first_fit_heap_allocator_tb;
  import ffha_pkg::*;

  localparam int unsigned HeapBytes = 4096;
  localparam int unsigned HeapSpan  = (HeapBytes / 2) * 2;
  localparam int unsigned HeapWords = HeapBytes / 2;
  localparam int unsigned AllocMark = 1;
  localparam int          RandItems = 940;
  localparam int          MaxShown  = 10;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] addr;
  } grant_t;

  typedef enum logic {
    ROW_FIXED,
    ROW_TAIL
  } row_kind_e;

  typedef struct {
    row_kind_e   kind;
    int          arg;
    logic        checked;
    logic [1:0]  status;
    logic [15:0] addr;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [15:0] request_size_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  status_o;
  logic [15:0] payload_address_o;

  logic [15:0] heap_tags [HeapWords];
  grant_t      pending_grants [$];
  row_t        plan [15];
  int          fail_cnt = 0;
  int          mismatch_cnt = 0;
  bit          steady = 1'b0;

  // Fixed expectation for the item on the request port, when typed in the plan.
  logic        row_checked = 1'b0;
  logic [1:0]  row_status = STATUS_GRANT;
  logic [15:0] row_addr = '0;

  first_fit_heap_allocator #(
    .HEAP_BYTES(HeapBytes)
  ) u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .request_size_i   (request_size_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .payload_address_o(payload_address_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic int unsigned tag_rd(int unsigned pos);
    if ((pos >> 1) >= HeapWords) return 0;
    return heap_tags[pos >> 1];
  endfunction

  function automatic void tag_wr(int unsigned pos, int unsigned value);
    if ((pos >> 1) < HeapWords) heap_tags[pos >> 1] = value[15:0];
  endfunction

  // Walk the blocks first-fit and claim one, splitting off the remainder if it is big enough.
  function automatic grant_t alloc_predict(logic [15:0] req);
    grant_t      res;
    int unsigned need, rounded, total, pos, tag, payload, blk, rest;
    res.status = STATUS_NO_FIT;
    res.addr = '0;
    need = req;
    if (need >= HeapSpan - 4) begin
      res.status = STATUS_TOO_BIG;
      return res;
    end
    rounded = (need + 1) & ~32'd1;
    total = rounded + 4;
    pos = 0;
    while (pos + 4 <= HeapSpan) begin
      tag = tag_rd(pos);
      payload = tag & ~AllocMark;
      blk = payload + 4;
      if (pos + blk > HeapSpan) break;
      if ((tag & AllocMark) == 0 && payload >= rounded) begin
        if (blk > total + 4) begin
          rest = payload - total;
          tag_wr(pos, rounded | AllocMark);
          tag_wr(pos + rounded + 2, rounded | AllocMark);
          tag_wr(pos + total, rest);
          tag_wr(pos + payload + 2, rest);
        end else begin
          tag_wr(pos, payload | AllocMark);
          tag_wr(pos + payload + 2, payload | AllocMark);
        end
        res.status = STATUS_GRANT;
        res.addr = 16'(pos + 2);
        return res;
      end
      pos += blk;
    end
    return res;
  endfunction

  // Payload of the first free block, or -1 once the heap is used up.
  function automatic int free_tail();
    int unsigned pos, tag, payload;
    pos = 0;
    while (pos + 4 <= HeapSpan) begin
      tag = tag_rd(pos);
      payload = tag & ~AllocMark;
      if (pos + payload + 4 > HeapSpan) break;
      if ((tag & AllocMark) == 0) return int'(payload);
      pos += payload + 4;
    end
    return -1;
  endfunction

  task automatic flag_mismatch(string what, int unsigned want, int unsigned got);
    fail_cnt++;
    mismatch_cnt++;
    if (mismatch_cnt <= MaxShown) begin
      $display("mismatch %s: expected %0d, got %0d", what, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    grant_t want;
    if (in_valid_i && in_ready_o) begin
      want = alloc_predict(request_size_i);
      if (row_checked) begin
        want.status = row_status;
        want.addr = row_addr;
      end
      pending_grants.push_back(want);
    end
    if (out_valid_o && out_ready_i) begin
      if (pending_grants.size() == 0) begin
        flag_mismatch("unexpected result, status", 0, status_o);
      end else begin
        want = pending_grants.pop_front();
        if (status_o !== want.status) flag_mismatch("status", want.status, status_o);
        if (payload_address_o !== want.addr) begin
          flag_mismatch("payload_address", want.addr, payload_address_o);
        end
      end
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(0, 99) >= 22);
  end

  // Call at a falling edge; returns at the edge where the item is taken.
  task automatic send_request(logic [15:0] size, logic checked, logic [1:0] st,
                              logic [15:0] addr);
    if (!steady && $urandom_range(0, 99) < 22) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    row_checked = checked;
    row_status = st;
    row_addr = addr;
    request_size_i <= size;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int          tail;
    int          val;
    int unsigned pick;
    logic [15:0] size;

    plan = '{
      '{ROW_FIXED, 0,          1'b1, STATUS_GRANT,   16'd2},
      '{ROW_FIXED, 'hFFFF,     1'b1, STATUS_TOO_BIG, 16'd0},
      '{ROW_FIXED, HeapSpan-4, 1'b1, STATUS_TOO_BIG, 16'd0},
      '{ROW_FIXED, HeapSpan-5, 1'b1, STATUS_NO_FIT,  16'd0},
      '{ROW_FIXED, 'h8000,     1'b1, STATUS_TOO_BIG, 16'd0},
      '{ROW_FIXED, 1,          1'b0, STATUS_GRANT,   16'd0},
      '{ROW_FIXED, 2,          1'b0, STATUS_GRANT,   16'd0},
      '{ROW_FIXED, 3,          1'b0, STATUS_GRANT,   16'd0},
      '{ROW_FIXED, 'h0FF6,     1'b0, STATUS_GRANT,   16'd0},
      '{ROW_TAIL,  1,          1'b0, STATUS_GRANT,   16'd0},
      '{ROW_TAIL,  2,          1'b0, STATUS_GRANT,   16'd0},
      '{ROW_FIXED, 64,         1'b0, STATUS_GRANT,   16'd0},
      '{ROW_FIXED, 100,        1'b0, STATUS_GRANT,   16'd0},
      '{ROW_FIXED, 'h4000,     1'b1, STATUS_TOO_BIG, 16'd0},
      '{ROW_FIXED, 'h7FFF,     1'b1, STATUS_TOO_BIG, 16'd0}
    };

    foreach (heap_tags[i]) heap_tags[i] = '0;
    heap_tags[0] = 16'(HeapSpan - 4);
    heap_tags[HeapWords - 1] = 16'(HeapSpan - 4);

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      @(negedge clk_i);
      if (plan[i].kind == ROW_TAIL) size = 16'(free_tail() + plan[i].arg);
      else size = 16'(plan[i].arg);
      send_request(size, plan[i].checked, plan[i].status, plan[i].addr);
    end
    wait_drained();

    for (int n = 0; n < RandItems; n++) begin
      if (n == 500) wait_drained();
      @(negedge clk_i);
      steady = (n >= 250 && n < 400);
      pick = $urandom_range(0, 99);
      tail = free_tail();
      if (pick < 60) begin
        size = 16'($urandom_range(0, 16));
      end else if (pick < 68) begin
        size = 16'($urandom_range(0, 64));
      end else if (pick < 72) begin
        size = 16'($urandom_range(0, 300));
      end else if (pick < 80 && tail >= 0 && tail < 600) begin
        // Aim at the first free block: whole fit, tiny remainder, or just too big.
        if ($urandom_range(0, 1) == 0) begin
          val = tail - int'($urandom_range(0, 12));
          if (val < 0) val = 0;
        end else begin
          val = tail + int'($urandom_range(1, 6));
        end
        size = 16'(val);
      end else if (pick < 80) begin
        size = 16'($urandom_range(0, 16));
      end else if (pick < 90) begin
        size = 16'($urandom_range(HeapSpan - 4, 65535));
      end else begin
        size = 16'($urandom);
      end
      send_request(size, 1'b0, STATUS_GRANT, '0);
    end
    steady = 1'b0;
    wait_drained();
    repeat (40) @(posedge clk_i);

    if (fail_cnt == 0 && pending_grants.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #(200_000_000);
    $display("TEST FAILED");
    $finish;
  end

endmodule
